/* src/rrts_pkg.sv */
// ---------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round-robin tick scheduler: field
// widths, activity and register codes, phase and controller state enums,
// queue entry and command structs.
package rrts_pkg;

  localparam int unsigned WORD_W      = 16;
  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPATCH = 1'b1;

  localparam logic [CFG_W-1:0] QUANTUM_RST  = 8'd4;
  localparam logic [CFG_W-1:0] DISPATCH_RST = 8'd1;

  // Activity codes reported with each tick
  localparam logic [ACT_W-1:0] ACT_IDLE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RUN      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_EXIT     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PREEMPT  = 3'd4;

  // Scheduler phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'b001,
    PH_DISPATCH = 3'b010,
    PH_RUN      = 3'b100
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_WAIT = 2'b01,
    ST_TICK = 2'b10
  } ctrl_state_t;

  // One ready-queue entry
  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] arrival;
    logic [WORD_W-1:0] request;
    logic [WORD_W-1:0] used;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_in;   // input transfer this cycle
    logic do_tick;   // evaluate the tick and load the result register
  } cmd_t;

endpackage

/* src/round_robin_tick_scheduler_unit.sv */
// ---------------------------------------------------------------------------
// round_robin_tick_scheduler_unit
// Round-robin tick scheduler with dispatch overhead and a bounded ready queue.
// ---------------------------------------------------------------------------
// Usage:
//   Each input transfer is one tick. in_tuser[0] marks a task arrival whose
//   id and requested run ticks ride in in_tdata. Every tick yields exactly
//   one status transfer on the out_ channel (activity in out_tuser).
//   Configuration writes (quantum and dispatch length) go over the cfg_
//   channel, which is always ready; write only while the block is idle.
// Timing:
//   The block takes no new input until the current tick is evaluated. The
//   input transfer appends the arrival and reads the queue head through the
//   memory's read port; the evaluation step then evaluates the tick, writes
//   the head back or rotates it to the tail, and loads the result register.
// Reset (rst_n low, synchronous): queue empty, tick count zero, scheduler
//   idle, quantum 4, dispatch length 1. No clearing pass is needed.
// Back-pressure: the result waits in its output register; the next input is
//   still taken, and its evaluation holds until the receiver takes the
//   waiting transfer.
// ---------------------------------------------------------------------------
module round_robin_tick_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] new_task_id, [31:16] new_task_request
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] arrival_valid
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] tick_number, [31:16] task_id,
                                             // [47:32] used_ticks, [63:48] wait_ticks,
                                             // [79:64] turnaround_ticks,
                                             // [80] arrival_dropped, [87:81] zero
  output logic [OUT_TUSER_W-1:0] out_tuser,  // [2:0] activity
  // Configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  cmd_t              cmd;
  logic [WORD_W-1:0] tick_number, task_id, used_ticks, wait_ticks, turnaround_ticks;
  logic [ACT_W-1:0]  activity;
  logic              arrival_dropped;

  assign cfg_ready = 1'b1;

  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rrts_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .arrival_valid    (in_tuser[0]),
    .new_task_id      (in_tdata[15:0]),
    .new_task_request (in_tdata[31:16]),
    .tick_number      (tick_number),
    .activity         (activity),
    .task_id          (task_id),
    .used_ticks       (used_ticks),
    .wait_ticks       (wait_ticks),
    .turnaround_ticks (turnaround_ticks),
    .arrival_dropped  (arrival_dropped)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {7'b0, arrival_dropped, turnaround_ticks, wait_ticks,
                      used_ticks, task_id, tick_number};
  assign out_tuser = activity;

endmodule

/* src/rrts_ctrl.sv */
// ---------------------------------------------------------------------------
// rrts_ctrl
// Handshake controller: takes one input transfer, then schedules the tick
// evaluation once the result register is free, and owns the result valid.
// ---------------------------------------------------------------------------
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        take_in;
  logic        do_tick;

  // Accept input only between ticks; evaluate when the result slot frees up
  assign in_tready = (state_r == ST_WAIT);
  assign take_in   = in_tvalid & in_tready;
  assign do_tick   = (state_r == ST_TICK) & (~out_valid_r | out_tready);

  assign cmd.take_in = take_in;
  assign cmd.do_tick = do_tick;
  assign out_tvalid  = out_valid_r;

  // Advance the state machine
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_WAIT: begin
        if (take_in) state_nxt = ST_TICK;
      end
      ST_TICK: begin
        if (do_tick) state_nxt = ST_WAIT;
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  // Hold the result valid until the receiver takes the transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/rrts_dp.sv */
// ---------------------------------------------------------------------------
// rrts_dp
// Scheduler datapath: ready-queue memory with pointers, phase and counters,
// configuration registers and the result register.
// ---------------------------------------------------------------------------
module rrts_dp
  import rrts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic                   cfg_wr,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   arrival_valid,
  input  logic [WORD_W-1:0]      new_task_id,
  input  logic [WORD_W-1:0]      new_task_request,
  output logic [WORD_W-1:0]      tick_number,
  output logic [ACT_W-1:0]       activity,
  output logic [WORD_W-1:0]      task_id,
  output logic [WORD_W-1:0]      used_ticks,
  output logic [WORD_W-1:0]      wait_ticks,
  output logic [WORD_W-1:0]      turnaround_ticks,
  output logic                   arrival_dropped
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  // Ready queue memory
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  entry_t             wr_data;

  // Configuration
  logic [CFG_W-1:0] quantum_r, dispatch_r;

  // Scheduler state
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [WORD_W-1:0] tick_r, tick_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CFG_W-1:0]  disp_cnt_r, disp_cnt_nxt;
  logic [CFG_W-1:0]  quant_cnt_r, quant_cnt_nxt;

  // Per-tick staging between input transfer and evaluation
  logic   dropped_r, dropped_nxt;
  logic   fwd_r, fwd_nxt;
  entry_t fwd_entry_r;
  entry_t new_entry;

  // Result register
  logic [WORD_W-1:0] res_tick_r, res_id_r, res_used_r, res_wait_r, res_ta_r;
  logic [ACT_W-1:0]  res_act_r;
  logic              res_drop_r;
  logic [WORD_W-1:0] id_nxt, used_nxt, wait_nxt, ta_nxt;
  logic [ACT_W-1:0]  act_nxt;

  // Address arithmetic and tick evaluation terms
  logic             full;
  logic             arrive;
  logic [SUM_W-1:0] app_sum;
  logic [PTR_W-1:0] app_slot, tail_slot, head_inc;
  entry_t           cur;
  logic [WORD_W-1:0] u;
  logic [CFG_W-1:0]  quant_new;
  logic [WORD_W-1:0] ta;
  logic              disp_more;

  assign full   = (occ_r == DEPTH_C);
  assign arrive = cmd.take_in & arrival_valid;

  assign new_entry.id      = new_task_id;
  assign new_entry.arrival = tick_r;
  assign new_entry.request = new_task_request;
  assign new_entry.used    = '0;

  // Wrap head plus occupancy into the ring
  assign app_sum  = SUM_W'(head_r) + SUM_W'(occ_r);
  assign app_slot = (app_sum >= DEPTH_S) ? PTR_W'(app_sum - DEPTH_S) : PTR_W'(app_sum);
  assign tail_slot = app_slot;
  assign head_inc  = (head_r == LAST_P) ? '0 : head_r + 1'b1;

  // Head entry, taken from the bypass when it was written this tick
  assign cur       = fwd_r ? fwd_entry_r : rd_data_r;
  assign u         = cur.used + 1'b1;
  assign quant_new = quant_cnt_r + 1'b1;
  assign ta        = tick_r - cur.arrival;
  assign disp_more = ({1'b0, disp_cnt_r} + 9'd1) < {1'b0, dispatch_r};

  // Next-state and memory write selection
  always_comb begin
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    tick_nxt      = tick_r;
    phase_nxt     = phase_r;
    disp_cnt_nxt  = disp_cnt_r;
    quant_cnt_nxt = quant_cnt_r;
    dropped_nxt   = dropped_r;
    fwd_nxt       = fwd_r;
    wr_en         = 1'b0;
    wr_addr       = app_slot;
    wr_data       = new_entry;
    act_nxt       = ACT_IDLE;
    id_nxt        = '0;
    used_nxt      = '0;
    wait_nxt      = '0;
    ta_nxt        = '0;

    // Append the arrival, or flag it when the queue is full
    if (cmd.take_in) begin
      dropped_nxt = arrive & full;
      fwd_nxt     = arrive & (occ_r == '0);
      if (arrive && !full) begin
        wr_en   = 1'b1;
        occ_nxt = occ_r + 1'b1;
      end
    end

    // Evaluate the tick
    if (cmd.do_tick) begin
      tick_nxt = tick_r + 1'b1;
      fwd_nxt  = 1'b0;
      if (occ_r == '0) begin
        phase_nxt     = PH_IDLE;
        disp_cnt_nxt  = '0;
        quant_cnt_nxt = '0;
      end else begin
        id_nxt = cur.id;
        if (phase_r == PH_IDLE) begin
          phase_nxt    = PH_DISPATCH;
          disp_cnt_nxt = '0;
          act_nxt      = ACT_DISPATCH;
          used_nxt     = cur.used;
        end else if (phase_r == PH_DISPATCH && disp_more) begin
          disp_cnt_nxt = disp_cnt_r + 1'b1;
          act_nxt      = ACT_DISPATCH;
          used_nxt     = cur.used;
        end else begin
          disp_cnt_nxt  = '0;
          phase_nxt     = PH_RUN;
          quant_cnt_nxt = quant_new;
          used_nxt      = u;
          wr_en         = 1'b1;
          wr_addr       = head_r;
          wr_data       = cur;
          wr_data.used  = u;
          if (u >= cur.request) begin
            // Task done: free its slot
            wr_en         = 1'b0;
            ta_nxt        = ta;
            wait_nxt      = ta - cur.request;
            head_nxt      = head_inc;
            occ_nxt       = occ_r - 1'b1;
            phase_nxt     = PH_IDLE;
            quant_cnt_nxt = '0;
            act_nxt       = ACT_EXIT;
          end else if (quant_new >= quantum_r) begin
            // Quantum spent: move the task to the tail
            wr_addr       = tail_slot;
            head_nxt      = head_inc;
            phase_nxt     = PH_IDLE;
            quant_cnt_nxt = '0;
            act_nxt       = ACT_PREEMPT;
          end else begin
            act_nxt = ACT_RUN;
          end
        end
      end
    end
  end

  // Queue memory with registered read of the head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[head_r];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r   <= QUANTUM_RST;
      dispatch_r  <= DISPATCH_RST;
      head_r      <= '0;
      occ_r       <= '0;
      tick_r      <= '0;
      phase_r     <= PH_IDLE;
      disp_cnt_r  <= '0;
      quant_cnt_r <= '0;
      dropped_r   <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_QUANTUM:  quantum_r  <= cfg_data;
          CFG_DISPATCH: dispatch_r <= cfg_data;
          default:      ;
        endcase
      end
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      tick_r      <= tick_nxt;
      phase_r     <= phase_nxt;
      disp_cnt_r  <= disp_cnt_nxt;
      quant_cnt_r <= quant_cnt_nxt;
      dropped_r   <= dropped_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      fwd_entry_r <= new_entry;
    end
    if (cmd.do_tick) begin
      res_tick_r <= tick_r;
      res_act_r  <= act_nxt;
      res_id_r   <= id_nxt;
      res_used_r <= used_nxt;
      res_wait_r <= wait_nxt;
      res_ta_r   <= ta_nxt;
      res_drop_r <= dropped_r;
    end
  end

  assign tick_number      = res_tick_r;
  assign activity         = res_act_r;
  assign task_id          = res_id_r;
  assign used_ticks       = res_used_r;
  assign wait_ticks       = res_wait_r;
  assign turnaround_ticks = res_ta_r;
  assign arrival_dropped  = res_drop_r;

endmodule
